[hw/rtl/tlde_pkg.sv]
// Shared constants and request codes for the tree LCA / distance engine.
// No dependencies.
package tlde_pkg;

  localparam int NODE_W     = 10;
  localparam int MAX_NODES  = 1 << NODE_W;
  localparam int LOG_LEVELS = 11;
  localparam int LVL_W      = $clog2(LOG_LEVELS);
  localparam int JT_AW      = LVL_W + NODE_W;
  localparam int JT_DEPTH   = LOG_LEVELS * MAX_NODES;
  localparam int DEPTH_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int DIST_W     = 11;
  localparam int REQ_W      = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

endpackage

[hw/rtl/tlde_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module tlde_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[hw/rtl/tree_lca_distance_engine_core.sv]
// Binary-lifting LCA and tree distance engine, top level.
// Depends on tlde_pkg and tlde_ram (jump table and depth store).
//
// Channels: in_* (valid/ready) carries load, build and query words; out_*
// (valid/ready) returns ancestor and distance for each query; cfg_* writes
// node_count, taken at any time but meant only while the block is idle.
// A load writes the depth store and the level-zero jump-table entry when it
// is accepted. A build fills every level above zero for min(node_count,
// MAX_NODES) nodes with two dependent jump-table reads and a write per
// entry. A query reads both depths, lifts the deeper node level by level up
// to the top set bit of the depth gap with a jump-table read at each set
// bit, compares, and unless the lifted nodes meet, climbs both jointly (one
// read covers both) through every level, reads the parent and loads out_*.
// One word is processed at a time; in_ready is high whenever the sequencer
// is idle, also while a result waits in the output register.
// If the receiver stalls, a finished query holds in its last step until the
// output register is free.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops
// out_valid and sets node_count to 1024. Memory contents are not cleared;
// reads of unloaded entries return unspecified data.
module tree_lca_distance_engine_core
  import tlde_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_node_count,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [NODE_W-1:0]  in_node_a,
  input  logic [NODE_W-1:0]  in_parent_node,
  input  logic [DEPTH_W-1:0] in_node_depth,
  input  logic [NODE_W-1:0]  in_node_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  out_ancestor,
  output logic [DIST_W-1:0]  out_distance
);

  typedef enum logic [3:0] {
    S_IDLE, S_BLD_RD1, S_BLD_RD2, S_BLD_WR, S_Q_DEP, S_LIFT, S_LIFT_W,
    S_CMP, S_DOWN, S_DOWN_W, S_FIN, S_FIN_W, S_ANC_W
  } state_t;

  localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'(LOG_LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_BLAST = LVL_W'(LOG_LEVELS - 2);

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   node_count_r;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [NODE_W-1:0]    j_r, j_nxt;
  logic [NODE_W-1:0]    cnt_last_r, cnt_last_nxt;
  logic [NODE_W-1:0]    qa_r, qa_nxt, qb_r, qb_nxt;
  logic [NODE_W-1:0]    anc_r, anc_nxt;
  logic [DEPTH_W-1:0]   gap_r, gap_nxt, gap_sh;
  logic [DIST_W-1:0]    dsum_r, dsum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]    out_anc_r, out_anc_nxt;
  logic [DIST_W-1:0]    out_dist_r, out_dist_nxt;
  logic [COUNT_W-1:0]   n_eff;

  logic                 in_fire, out_free;
  logic                 jt_we;
  logic [JT_AW-1:0]     jt_waddr, jt_ra_addr, jt_rb_addr;
  logic [NODE_W-1:0]    jt_wdata, jt_ra_data, jt_rb_data;
  logic                 dp_we;
  logic [NODE_W-1:0]    dp_ra_addr;
  logic [DEPTH_W-1:0]   dp_ra_data, dp_rb_data;

  tlde_ram #(.DEPTH(JT_DEPTH), .WIDTH(NODE_W), .AW(JT_AW)) u_jump (
    .clk     (clk),
    .we      (jt_we),
    .waddr   (jt_waddr),
    .wdata   (jt_wdata),
    .ra_addr (jt_ra_addr),
    .ra_data (jt_ra_data),
    .rb_addr (jt_rb_addr),
    .rb_data (jt_rb_data)
  );

  tlde_ram #(.DEPTH(MAX_NODES), .WIDTH(DEPTH_W), .AW(NODE_W)) u_depth (
    .clk     (clk),
    .we      (dp_we),
    .waddr   (in_node_a),
    .wdata   (in_node_depth),
    .ra_addr (dp_ra_addr),
    .ra_data (dp_ra_data),
    .rb_addr (in_node_b),
    .rb_data (dp_rb_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_ancestor = out_anc_r;
  assign out_distance = out_dist_r;

  assign n_eff  = (node_count_r > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count_r;
  assign gap_sh = gap_r >> 1;

  // memory ports
  always_comb begin
    jt_we    = 1'b0;
    jt_waddr = {LVL_W'(0), in_node_a};
    jt_wdata = in_parent_node;
    dp_we    = in_fire && (in_req_type == REQ_LOAD);
    if (dp_we) begin
      jt_we = 1'b1;
    end else if (state_r == S_BLD_WR) begin
      jt_we    = 1'b1;
      jt_waddr = {lvl_r + LVL_W'(1), j_r};
      jt_wdata = jt_ra_data;
    end

    case (state_r)
      S_BLD_RD1: jt_ra_addr = {lvl_r, j_r};
      S_BLD_RD2: jt_ra_addr = {lvl_r, jt_ra_data};
      S_FIN:     jt_ra_addr = {LVL_W'(0), qa_r};
      default:   jt_ra_addr = {lvl_r, qa_r};
    endcase
    jt_rb_addr = {lvl_r, qb_r};

    case (state_r)
      S_IDLE:  dp_ra_addr = in_node_a;
      S_CMP:   dp_ra_addr = qa_r;
      S_FIN_W: dp_ra_addr = jt_ra_data;
      default: dp_ra_addr = anc_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    cnt_last_nxt  = cnt_last_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    anc_nxt       = anc_r;
    gap_nxt       = gap_r;
    dsum_nxt      = dsum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_anc_nxt   = out_anc_r;
    out_dist_nxt  = out_dist_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_BUILD: begin
              if (node_count_r != '0) begin
                cnt_last_nxt = NODE_W'(n_eff - COUNT_W'(1));
                lvl_nxt      = '0;
                j_nxt        = '0;
                state_nxt    = S_BLD_RD1;
              end
            end
            REQ_QUERY: begin
              qa_nxt    = in_node_a;
              qb_nxt    = in_node_b;
              state_nxt = S_Q_DEP;
            end
            default: ;
          endcase
        end
      end
      S_BLD_RD1: state_nxt = S_BLD_RD2;
      S_BLD_RD2: state_nxt = S_BLD_WR;
      S_BLD_WR: begin
        state_nxt = S_BLD_RD1;
        if (j_r == cnt_last_r) begin
          j_nxt = '0;
          if (lvl_r == LVL_BLAST) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end else begin
          j_nxt = j_r + NODE_W'(1);
        end
      end
      S_Q_DEP: begin
        dsum_nxt = DIST_W'(dp_ra_data) + DIST_W'(dp_rb_data);
        lvl_nxt  = '0;
        if (dp_ra_data > dp_rb_data) begin
          qa_nxt  = qb_r;
          qb_nxt  = qa_r;
          gap_nxt = dp_ra_data - dp_rb_data;
        end else begin
          gap_nxt = dp_rb_data - dp_ra_data;
        end
        state_nxt = S_LIFT;
      end
      S_LIFT, S_LIFT_W: begin
        if (state_r == S_LIFT && gap_r[0]) begin
          state_nxt = S_LIFT_W;
        end else begin
          if (state_r == S_LIFT_W) begin
            qb_nxt = jt_rb_data;
          end
          gap_nxt = gap_sh;
          if (lvl_r == LVL_LAST || gap_sh == '0) begin
            state_nxt = S_CMP;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            state_nxt = S_LIFT;
          end
        end
      end
      S_CMP: begin
        if (qa_r == qb_r) begin
          anc_nxt   = qa_r;
          state_nxt = S_ANC_W;
        end else begin
          lvl_nxt   = LVL_LAST;
          state_nxt = S_DOWN;
        end
      end
      S_DOWN: state_nxt = S_DOWN_W;
      S_DOWN_W: begin
        if (jt_ra_data != jt_rb_data) begin
          qa_nxt = jt_ra_data;
          qb_nxt = jt_rb_data;
        end
        if (lvl_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_DOWN;
        end
      end
      S_FIN: state_nxt = S_FIN_W;
      S_FIN_W: begin
        anc_nxt   = jt_ra_data;
        state_nxt = S_ANC_W;
      end
      S_ANC_W: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt   = anc_r;
          out_dist_nxt  = dsum_r - {dp_ra_data, 1'b0};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= COUNT_W'(MAX_NODES);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
    lvl_r      <= lvl_nxt;
    j_r        <= j_nxt;
    cnt_last_r <= cnt_last_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    anc_r      <= anc_nxt;
    gap_r      <= gap_nxt;
    dsum_r     <= dsum_nxt;
    out_anc_r  <= out_anc_nxt;
    out_dist_r <= out_dist_nxt;
  end

  // no table writes while a query walks the table
  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIFT || state_r == S_LIFT_W || state_r == S_DOWN ||
     state_r == S_DOWN_W || state_r == S_FIN || state_r == S_FIN_W) |-> !jt_we)
    else $error("jump table written during query");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == REQ_QUERY) |=> (state_r == S_Q_DEP))
    else $error("query did not start with depth fetch");

  // build never overwrites level zero
  a_build_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLD_WR) |-> (lvl_r <= LVL_BLAST))
    else $error("build level out of range");

  a_result_only_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) && out_valid_nxt |-> (state_r == S_ANC_W))
    else $error("result produced outside final query step");

endmodule
